### src/fdtd_pkg.sv
// Package for the one-dimensional FDTD field engine.
// Holds the data width, the item kinds and the register indexes.
// No dependencies.
package fdtd_pkg;

  localparam int DW = 32;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOSS = 2'd0;
  localparam kind_t KIND_CURL = 2'd1;
  localparam kind_t KIND_STEP = 2'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MAG_COEF  = 2'd0;
  localparam reg_idx_t REG_SRC_COEF  = 2'd1;
  localparam reg_idx_t REG_SRC_CELL  = 2'd2;
  localparam reg_idx_t REG_RANGE     = 2'd3;

  localparam logic [9:0]  SRC_CELL_RST = 10'd511;
  localparam logic [15:0] RANGE_RST    = 16'd600;

endpackage

### src/fdtd_1d_field_step_core.sv
// Top level of the one-dimensional lossy FDTD field engine.
// Depends on fdtd_pkg; holds the Ey, Hz, loss and curl memories.
//
// A time step runs the Ey sweep up to s, the source update at s, the Ey mirror, the
// Hz sweep, the Hz mirror and, while the peak trackers are active, a peak pass over
// all cells; s is the clamped source cell. Every cell goes through one memory read
// port per array. The result strobe is high for one cycle, in the cycle that busy
// falls. Load items do not raise busy.
// After reset the Ey and Hz memories are cleared with busy high.
module fdtd_1d_field_step_core #(
  parameter int GRID_CELLS = 1024,
  parameter int FRAC_BITS  = 28
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  fdtd_pkg::kind_t                 in_kind,
  input  logic [9:0]                      in_cell_index,
  input  logic signed [fdtd_pkg::DW-1:0]  in_coef_value,
  input  logic signed [fdtd_pkg::DW-1:0]  in_source_sample,
  output logic                            out_valid,
  output logic signed [fdtd_pkg::DW-1:0]  out_ey_at_source,
  output logic signed [fdtd_pkg::DW-1:0]  out_ey_peak_high,
  output logic signed [fdtd_pkg::DW-1:0]  out_ey_peak_low,
  output logic signed [fdtd_pkg::DW-1:0]  out_hz_peak_high,
  output logic signed [fdtd_pkg::DW-1:0]  out_hz_peak_low,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import fdtd_pkg::*;

  localparam int AW = $clog2(GRID_CELLS);
  localparam int HALF = (GRID_CELLS - 1) / 2;
  localparam logic [AW-1:0] LAST   = AW'(GRID_CELLS - 1);
  localparam logic [AW-1:0] LAST_H = AW'(GRID_CELLS - 2);
  localparam logic [AW-1:0] HALF_A = AW'(HALF);
  localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_EH0  = 4'd2;
  localparam logic [3:0] ST_E    = 4'd3;
  localparam logic [3:0] ST_SRC  = 4'd4;
  localparam logic [3:0] ST_MIR  = 4'd5;
  localparam logic [3:0] ST_HE0  = 4'd6;
  localparam logic [3:0] ST_H    = 4'd7;
  localparam logic [3:0] ST_HMIR = 4'd8;
  localparam logic [3:0] ST_TRK  = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -33'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Round half up, floor by the fraction bits, saturate to 32 bits.
  function automatic logic signed [31:0] fin(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + RND) >>> FRAC_BITS;
    if (t > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (t < -64'sh8000_0000) return 32'sh8000_0000;
    return t[31:0];
  endfunction

  // Configuration registers.
  logic signed [31:0] mag_coef_r, src_coef_r;
  logic [9:0]         src_cell_r;
  logic [15:0]        range_r;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_coef_r <= '0;
      src_coef_r <= '0;
      src_cell_r <= SRC_CELL_RST;
      range_r    <= RANGE_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_MAG_COEF: mag_coef_r <= pwdata;
        REG_SRC_COEF: src_coef_r <= pwdata;
        REG_SRC_CELL: src_cell_r <= pwdata[9:0];
        REG_RANGE:    range_r    <= pwdata[15:0];
        default:      mag_coef_r <= mag_coef_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAG_COEF: prdata = mag_coef_r;
      REG_SRC_COEF: prdata = src_coef_r;
      REG_SRC_CELL: prdata = {22'd0, src_cell_r};
      REG_RANGE:    prdata = {16'd0, range_r};
      default:      prdata = '0;
    endcase
  end

  // Memories.
  logic signed [31:0] e_mem [GRID_CELLS];
  logic signed [31:0] h_mem [GRID_CELLS-1];
  logic signed [31:0] l_mem [GRID_CELLS];
  logic signed [31:0] c_mem [GRID_CELLS];
  logic signed [31:0] e_rd_r, h_rd_r, l_rd_r, c_rd_r;
  logic               e_we, h_we, l_we, c_we;
  logic [AW-1:0]      e_wa, h_wa, e_ra, h_ra, ld_a;
  logic signed [31:0] e_wd, h_wd;

  always_ff @(posedge clk) begin
    if (e_we) e_mem[e_wa] <= e_wd;
    e_rd_r <= e_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (h_we) h_mem[h_wa] <= h_wd;
    h_rd_r <= h_mem[h_ra];
  end

  // Sequencer.
  logic [3:0]         st_r, st_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [AW-1:0]      x_r, x_nxt, s_r, s_nxt;
  logic signed [31:0] sample_r, sample_nxt, prev_r, prev_nxt, d_r, d_nxt;
  logic signed [31:0] a_r, a_nxt, curl_r, curl_nxt, eo_r, eo_nxt;
  logic signed [63:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic               trk_r, trk_nxt, outv_r, outv_nxt;
  logic signed [31:0] eyh_r, eyh_nxt, eyl_r, eyl_nxt, hzh_r, hzh_nxt, hzl_r, hzl_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic signed [31:0] upd_v;
  logic               accept, idx_ok;
  logic [31:0]        src_ext;

  // Loss and curl tables are read at the running cell; only the Ey sweep uses the data.
  always_ff @(posedge clk) begin
    if (l_we) l_mem[ld_a] <= in_coef_value;
    l_rd_r <= l_mem[x_r];
  end

  always_ff @(posedge clk) begin
    if (c_we) c_mem[ld_a] <= in_coef_value;
    c_rd_r <= c_mem[x_r];
  end

  assign busy    = (st_r != ST_IDLE);
  assign accept  = start & ~busy;
  assign idx_ok  = 32'(in_cell_index) < 32'(GRID_CELLS);
  assign ld_a    = AW'(in_cell_index);
  assign l_we    = accept & (in_kind == KIND_LOSS) & idx_ok;
  assign c_we    = accept & (in_kind == KIND_CURL) & idx_ok;
  assign src_ext = 32'(src_cell_r);
  assign upd_v   = sat33(33'(a_r) - 33'(fin(pb_r)));

  always_comb begin
    st_nxt = st_r;     sub_nxt = sub_r;   x_nxt = x_r;     s_nxt = s_r;
    sample_nxt = sample_r; prev_nxt = prev_r; d_nxt = d_r; a_nxt = a_r;
    curl_nxt = curl_r; eo_nxt = eo_r;     pa_nxt = pa_r;   pb_nxt = pb_r;
    trk_nxt = trk_r;   outv_nxt = 1'b0;   cnt_nxt = cnt_r;
    eyh_nxt = eyh_r;   eyl_nxt = eyl_r;   hzh_nxt = hzh_r; hzl_nxt = hzl_r;
    e_we = 1'b0; h_we = 1'b0; e_wa = x_r; h_wa = x_r; e_wd = '0; h_wd = '0;
    e_ra = x_r;  h_ra = '0;
    case (st_r)
      ST_CLR: begin
        e_we = 1'b1;
        h_we = (x_r != LAST);
        if (x_r == LAST) begin
          st_nxt = ST_IDLE;
          x_nxt  = '0;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept && in_kind == KIND_STEP) begin
          sample_nxt = in_source_sample;
          trk_nxt    = cnt_r < range_r;
          if (src_ext < 32'd1) s_nxt = AW'(1);
          else if (src_ext > 32'(GRID_CELLS - 2)) s_nxt = LAST_H;
          else s_nxt = AW'(src_ext);
          st_nxt  = ST_EH0;
          sub_nxt = 2'd0;
        end
      end
      ST_EH0: begin
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          prev_nxt = h_rd_r;
          x_nxt    = AW'(1);
          st_nxt   = ST_E;
          sub_nxt  = 2'd0;
        end
      end
      ST_E: begin
        h_ra = x_r;
        case (sub_r)
          2'd0: sub_nxt = 2'd1;
          2'd1: begin
            d_nxt    = sat33(33'(h_rd_r) - 33'(prev_r));
            prev_nxt = h_rd_r;
            pa_nxt   = l_rd_r * e_rd_r;
            curl_nxt = c_rd_r;
            sub_nxt  = 2'd2;
          end
          2'd2: begin
            pb_nxt  = curl_r * d_r;
            a_nxt   = fin(pa_r);
            sub_nxt = 2'd3;
          end
          default: begin
            e_we    = 1'b1;
            e_wd    = upd_v;
            sub_nxt = 2'd0;
            if (x_r == s_r) st_nxt = ST_SRC;
            else x_nxt = x_r + 1'b1;
          end
        endcase
      end
      ST_SRC: begin
        e_ra = s_r;
        e_wa = s_r;
        case (sub_r)
          2'd0: sub_nxt = 2'd1;
          2'd1: begin
            a_nxt   = e_rd_r;
            pb_nxt  = src_coef_r * sample_r;
            sub_nxt = 2'd2;
          end
          default: begin
            e_we    = 1'b1;
            e_wd    = upd_v;
            eo_nxt  = upd_v;
            sub_nxt = 2'd0;
            if (s_r == LAST_H) begin
              st_nxt = ST_HE0;
            end else begin
              st_nxt = ST_MIR;
              x_nxt  = s_r + 1'b1;
            end
          end
        endcase
      end
      ST_MIR: begin
        e_ra = LAST - x_r;
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          e_we    = 1'b1;
          e_wd    = e_rd_r;
          sub_nxt = 2'd0;
          if (x_r == LAST_H) st_nxt = ST_HE0;
          else x_nxt = x_r + 1'b1;
        end
      end
      ST_HE0: begin
        e_ra = '0;
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          prev_nxt = e_rd_r;
          x_nxt    = '0;
          st_nxt   = ST_H;
          sub_nxt  = 2'd0;
        end
      end
      ST_H: begin
        e_ra = x_r + 1'b1;
        h_ra = x_r;
        case (sub_r)
          2'd0: sub_nxt = 2'd1;
          2'd1: begin
            d_nxt    = sat33(33'(e_rd_r) - 33'(prev_r));
            prev_nxt = e_rd_r;
            a_nxt    = h_rd_r;
            sub_nxt  = 2'd2;
          end
          2'd2: begin
            pb_nxt  = mag_coef_r * d_r;
            sub_nxt = 2'd3;
          end
          default: begin
            h_we    = 1'b1;
            h_wd    = upd_v;
            sub_nxt = 2'd0;
            if (x_r == HALF_A - 1'b1) begin
              st_nxt = ST_HMIR;
              x_nxt  = HALF_A;
            end else begin
              x_nxt = x_r + 1'b1;
            end
          end
        endcase
      end
      ST_HMIR: begin
        h_ra = LAST_H - x_r;
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          h_we    = 1'b1;
          h_wd    = sat33(-33'(h_rd_r));
          sub_nxt = 2'd0;
          if (x_r == LAST_H) begin
            x_nxt  = '0;
            st_nxt = trk_r ? ST_TRK : ST_DONE;
          end else begin
            x_nxt = x_r + 1'b1;
          end
        end
      end
      ST_TRK: begin
        // The last Ey cell has no Hz partner.
        h_ra = (x_r == LAST) ? '0 : x_r;
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          if (e_rd_r > eyh_r) eyh_nxt = e_rd_r;
          if (e_rd_r < eyl_r) eyl_nxt = e_rd_r;
          if (x_r != LAST) begin
            if (h_rd_r > hzh_r) hzh_nxt = h_rd_r;
            if (h_rd_r < hzl_r) hzl_nxt = h_rd_r;
          end
          sub_nxt = 2'd0;
          if (x_r == LAST) st_nxt = ST_DONE;
          else x_nxt = x_r + 1'b1;
        end
      end
      ST_DONE: begin
        outv_nxt = 1'b1;
        if (cnt_r != 16'hFFFF) cnt_nxt = cnt_r + 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      sub_r  <= '0;
      x_r    <= '0;
      trk_r  <= 1'b0;
      outv_r <= 1'b0;
      cnt_r  <= '0;
      eyh_r  <= '0;
      eyl_r  <= '0;
      hzh_r  <= '0;
      hzl_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      sub_r  <= sub_nxt;
      x_r    <= x_nxt;
      trk_r  <= trk_nxt;
      outv_r <= outv_nxt;
      cnt_r  <= cnt_nxt;
      eyh_r  <= eyh_nxt;
      eyl_r  <= eyl_nxt;
      hzh_r  <= hzh_nxt;
      hzl_r  <= hzl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r      <= s_nxt;
    sample_r <= sample_nxt;
    prev_r   <= prev_nxt;
    d_r      <= d_nxt;
    a_r      <= a_nxt;
    curl_r   <= curl_nxt;
    eo_r     <= eo_nxt;
    pa_r     <= pa_nxt;
    pb_r     <= pb_nxt;
  end

  assign out_valid        = outv_r;
  assign out_ey_at_source = eo_r;
  assign out_ey_peak_high = eyh_r;
  assign out_ey_peak_low  = eyl_r;
  assign out_hz_peak_high = hzh_r;
  assign out_hz_peak_low  = hzl_r;

endmodule

### verif/fdtd_1d_field_step_core_test.sv
// Self-checking testbench for the one-dimensional lossy FDTD field engine.
// It predicts every time-step result in a scoreboard class and drives the block's
// command and APB ports from plain tasks. Depends on fdtd_pkg and the core only.
`timescale 1ns / 100ps

typedef struct {
  logic signed [31:0] ey_src;
  logic signed [31:0] ey_hi;
  logic signed [31:0] ey_lo;
  logic signed [31:0] hz_hi;
  logic signed [31:0] hz_lo;
} field_peaks_t;

class field_scoreboard;
  localparam int CELLS = 1024;
  int errors;
  logic signed [31:0] ey [CELLS];
  logic signed [31:0] hz [CELLS-1];
  logic signed [31:0] loss_coef [CELLS];
  logic signed [31:0] curl_coef [CELLS];
  logic signed [31:0] ey_hi, ey_lo, hz_hi, hz_lo;
  int unsigned steps_seen;
  logic signed [31:0] mag_coef, src_coef;
  logic [9:0] src_cell;
  logic [15:0] track_steps;
  field_peaks_t awaited [$];

  function new();
    foreach (ey[i]) ey[i] = 0;
    foreach (hz[i]) hz[i] = 0;
    foreach (loss_coef[i]) loss_coef[i] = 0;
    foreach (curl_coef[i]) curl_coef[i] = 0;
    ey_hi = 0; ey_lo = 0; hz_hi = 0; hz_lo = 0;
    steps_seen = 0;
    mag_coef = 0;
    src_coef = 0;
    src_cell = fdtd_pkg::SRC_CELL_RST;
    track_steps = fdtd_pkg::RANGE_RST;
    errors = 0;
  endfunction

  function logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Exact product, add half an LSB, then floor by the fraction bits.
  function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b) + (64'sd1 <<< 27);
    return clip(p >>> 28);
  endfunction

  function void note_config(fdtd_pkg::reg_idx_t idx, logic [31:0] val);
    case (idx)
      fdtd_pkg::REG_MAG_COEF: mag_coef = val;
      fdtd_pkg::REG_SRC_COEF: src_coef = val;
      fdtd_pkg::REG_SRC_CELL: src_cell = val[9:0];
      fdtd_pkg::REG_RANGE:    track_steps = val[15:0];
      default: ;
    endcase
  endfunction

  function void note_item(fdtd_pkg::kind_t kind, logic [9:0] idx,
                          logic signed [31:0] coef, logic signed [31:0] smp);
    int s;
    logic signed [31:0] d;
    field_peaks_t r;
    if (kind == fdtd_pkg::KIND_LOSS) loss_coef[idx] = coef;
    else if (kind == fdtd_pkg::KIND_CURL) curl_coef[idx] = coef;
    if (kind != fdtd_pkg::KIND_STEP) return;
    s = src_cell;
    if (s < 1) s = 1;
    if (s > CELLS - 2) s = CELLS - 2;
    for (int x = 1; x <= s; x++) begin
      d = clip(longint'(hz[x]) - hz[x-1]);
      ey[x] = clip(longint'(qmul(loss_coef[x], ey[x])) - qmul(curl_coef[x], d));
    end
    ey[s] = clip(longint'(ey[s]) - qmul(src_coef, smp));
    for (int x = s + 1; x < CELLS - 1; x++) ey[x] = ey[CELLS-1-x];
    for (int x = 0; x < (CELLS - 1) / 2; x++) begin
      d = clip(longint'(ey[x+1]) - ey[x]);
      hz[x] = clip(longint'(hz[x]) - qmul(mag_coef, d));
    end
    for (int x = (CELLS - 1) / 2; x < CELLS - 1; x++) hz[x] = clip(-longint'(hz[CELLS-2-x]));
    if (steps_seen < track_steps) begin
      foreach (ey[x]) begin
        if (ey[x] > ey_hi) ey_hi = ey[x];
        if (ey[x] < ey_lo) ey_lo = ey[x];
      end
      foreach (hz[x]) begin
        if (hz[x] > hz_hi) hz_hi = hz[x];
        if (hz[x] < hz_lo) hz_lo = hz[x];
      end
    end
    if (steps_seen < 65535) steps_seen++;
    r.ey_src = ey[s];
    r.ey_hi = ey_hi;
    r.ey_lo = ey_lo;
    r.hz_hi = hz_hi;
    r.hz_lo = hz_lo;
    awaited.push_back(r);
  endfunction

  function void check(field_peaks_t got);
    field_peaks_t e;
    if (awaited.size() == 0) begin
      $display("%0t: result beat with nothing awaited, ey_at_source %h", $time, got.ey_src);
      errors++;
      return;
    end
    e = awaited.pop_front();
    if (got.ey_src !== e.ey_src) begin
      $display("%0t: ey_at_source expected %h actual %h", $time, e.ey_src, got.ey_src);
      errors++;
    end
    if (got.ey_hi !== e.ey_hi) begin
      $display("%0t: ey_peak_high expected %h actual %h", $time, e.ey_hi, got.ey_hi);
      errors++;
    end
    if (got.ey_lo !== e.ey_lo) begin
      $display("%0t: ey_peak_low expected %h actual %h", $time, e.ey_lo, got.ey_lo);
      errors++;
    end
    if (got.hz_hi !== e.hz_hi) begin
      $display("%0t: hz_peak_high expected %h actual %h", $time, e.hz_hi, got.hz_hi);
      errors++;
    end
    if (got.hz_lo !== e.hz_lo) begin
      $display("%0t: hz_peak_low expected %h actual %h", $time, e.hz_lo, got.hz_lo);
      errors++;
    end
  endfunction
endclass

module fdtd_1d_field_step_core_test;
  import fdtd_pkg::*;

  localparam kind_t KIND_SPARE = 2'd3;
  localparam longint CYCLE_LIMIT = 30_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  kind_t in_kind = KIND_SPARE;
  logic [9:0] in_cell_index = '0;
  logic signed [31:0] in_coef_value = '0;
  logic signed [31:0] in_source_sample = '0;
  logic out_valid;
  logic signed [31:0] out_ey_at_source, out_ey_peak_high, out_ey_peak_low;
  logic signed [31:0] out_hz_peak_high, out_hz_peak_low;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  field_scoreboard fields;
  longint cycles = 0;
  bit gaps_on;

  fdtd_1d_field_step_core dut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_cell_index, .in_coef_value,
    .in_source_sample, .out_valid, .out_ey_at_source, .out_ey_peak_high,
    .out_ey_peak_low, .out_hz_peak_high, .out_hz_peak_low,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    field_peaks_t got;
    if (rst_n && out_valid) begin
      got.ey_src = out_ey_at_source;
      got.ey_hi = out_ey_peak_high;
      got.ey_lo = out_ey_peak_low;
      got.hz_hi = out_hz_peak_high;
      got.hz_lo = out_hz_peak_low;
      fields.check(got);
    end
  end

  // One command beat; the strobe stays high when the next beat follows without a gap.
  task automatic push_item(kind_t kind, logic [9:0] idx, logic [31:0] coef, logic [31:0] smp);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_cell_index <= idx;
    in_coef_value <= coef;
    in_source_sample <= smp;
    @(posedge clk);
    while (busy) @(posedge clk);
    fields.note_item(kind, idx, coef, smp);
  endtask

  // Waits until every result is in and the block has had time to finish a load.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (fields.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    fields.note_config(idx, val);
  endtask

  task automatic set_regs(logic [31:0] mag, logic [31:0] src, logic [31:0] src_pos,
                          logic [31:0] span);
    write_reg(REG_MAG_COEF, mag);
    write_reg(REG_SRC_COEF, src);
    write_reg(REG_SRC_CELL, src_pos);
    write_reg(REG_RANGE, span);
  endtask

  // Mostly plausible coefficients so the fields evolve; now and then anything at all.
  function automatic logic [31:0] draw_coef(kind_t kind);
    if ($urandom_range(0, 3) == 0) return $urandom;
    if (kind == KIND_LOSS) return $urandom_range(32'h0e00_0000, 32'h1000_0000);
    return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
  endfunction

  task automatic random_items(int count);
    int pick;
    kind_t k;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      k = pick < 5 ? KIND_STEP : pick < 7 ? KIND_LOSS : pick < 9 ? KIND_CURL : KIND_SPARE;
      push_item(k, 10'($urandom), draw_coef(k),
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h2000_0000));
    end
  endtask

  initial begin
    fields = new();
    gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Every table entry is loaded before the first step reads it.
    gaps_on = 1'b0;
    for (int c = 0; c < 1024; c++) begin
      push_item(KIND_LOSS, 10'(c), 32'h0f80_0000, 32'h0);
      push_item(KIND_CURL, 10'(c), 32'h0040_0000, 32'h0);
    end
    drain();
    set_regs(32'h0100_0000, 32'h0400_0000, 511, 600);

    // Directed beats: field extremes, the spare kind and both ends of the source.
    gaps_on = 1'b1;
    push_item(KIND_STEP, 0, 0, 32'h7fff_ffff);
    push_item(KIND_STEP, 0, 0, 32'h8000_0000);
    push_item(KIND_SPARE, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff);
    push_item(KIND_STEP, 10'h3ff, 32'h7fff_ffff, 32'h1000_0000);
    push_item(KIND_LOSS, 511, 32'h7fff_ffff, 0);
    push_item(KIND_CURL, 510, 32'h8000_0000, 0);
    push_item(KIND_LOSS, 0, 32'h8000_0000, 0);
    push_item(KIND_CURL, 1023, 32'h7fff_ffff, 0);
    push_item(KIND_STEP, 0, 0, 32'h7fff_ffff);
    push_item(KIND_STEP, 0, 0, 0);
    push_item(KIND_STEP, 0, 0, 32'h8000_0000);
    push_item(KIND_LOSS, 511, 32'h0f00_0000, 0);
    push_item(KIND_CURL, 510, 32'h0010_0000, 0);
    push_item(KIND_STEP, 0, 0, 32'h1000_0000);
    drain();
    set_regs(32'h7fff_ffff, 32'h8000_0000, 0, 0);
    push_item(KIND_STEP, 0, 0, 32'h7fff_ffff);
    push_item(KIND_STEP, 0, 0, 32'h0800_0000);
    drain();
    set_regs(32'h8000_0000, 32'h7fff_ffff, 1023, 65535);
    push_item(KIND_STEP, 0, 0, 32'h8000_0000);
    push_item(KIND_STEP, 0, 0, 32'h0800_0000);
    drain();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      gaps_on = ph[0];
      case (ph)
        0: set_regs(32'h0200_0000, 32'h0800_0000, 1, 5);
        1: set_regs(32'h0080_0000, 32'h0400_0000, 1022, 400);
        2: set_regs($urandom, $urandom, $urandom_range(1, 1022), $urandom);
        3: set_regs(32'h0100_0000, 32'hfc00_0000, 0, 3);
        4: set_regs($urandom_range(0, 32'h0400_0000), $urandom, 1023, 65535);
        default: set_regs($urandom, $urandom, $urandom, $urandom_range(0, 20));
      endcase
      random_items(72);
      drain();
    end

    repeat (200) @(posedge clk);
    if (fields.errors == 0 && fields.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
